// ===== rtl/core/mep_pkg.sv =====
// Package for the maximum-value expression parenthesization core.
// Holds the sizing constants, operator codes and the structs shared by the modules.
// Depends on nothing.
`timescale 1ns / 1ps

package mep_pkg;

   // Sizing of the interval tables and the digit counter.
   localparam int MAX_DIGITS = 16;
   localparam int IDX_W      = $clog2(MAX_DIGITS);
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int DEPTH      = MAX_DIGITS * MAX_DIGITS;
   localparam int ADDR_W     = $clog2(DEPTH);

   // Field widths of the transactions.
   localparam int DIGIT_W   = 4;
   localparam int MODE_W    = 2;
   localparam int DIGIT_MAX = 9;
   localparam int VALUE_W   = 52;
   localparam int HALF_W    = VALUE_W / 2;
   localparam int NUM_PROD  = 4;

   typedef enum logic [MODE_W-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2
   } op_type;

   typedef logic signed [VALUE_W-1:0] value_type;

   // One interval table entry: greatest and least reachable value.
   typedef struct packed {
      value_type hi;
      value_type lo;
   } entry_type;

   // One split evaluation travelling down the split pipeline.
   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last;
      op_type            op;
      logic [ADDR_W-1:0] addr;
   } token_type;

   // Write request into the interval memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } write_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [MODE_W-1:0]  mode;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] max_value;
      logic signed [VALUE_W-1:0] min_value;
      logic                      too_long;
   } rsp_type;

endpackage

// ===== rtl/core/mep_interval_ram.sv =====
// Interval memory holding the max/min pair of every sub-range.
// One write port, two read ports, read data registered. Uses mep_pkg.
`timescale 1ns / 1ps

module mep_interval_ram (
   input  logic                        clock,
   input  mep_pkg::write_type          wr,
   input  logic [mep_pkg::ADDR_W-1:0]  rd_addr_a,
   input  logic [mep_pkg::ADDR_W-1:0]  rd_addr_b,
   output mep_pkg::entry_type          rd_data_a,
   output mep_pkg::entry_type          rd_data_b
);

   mep_pkg::entry_type mem [mep_pkg::DEPTH];
   mep_pkg::entry_type rd_a_ff;
   mep_pkg::entry_type rd_b_ff;

   // Synchronous write and two registered reads.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/mep_split_unit.sv =====
// Split pipeline: combines the two sub-range entries of one split and folds the
// candidates of an interval into its max/min, then requests the write-back. Uses mep_pkg.
`timescale 1ns / 1ps

module mep_split_unit (
   input  logic                clock,
   input  logic                reset,
   input  mep_pkg::token_type  tok_in,
   input  mep_pkg::entry_type  left_data,
   input  mep_pkg::entry_type  right_data,
   output mep_pkg::write_type  wb
);

   function automatic mep_pkg::value_type smax(input mep_pkg::value_type a,
                                               input mep_pkg::value_type b);
      smax = (a > b) ? a : b;
   endfunction

   function automatic mep_pkg::value_type smin(input mep_pkg::value_type a,
                                               input mep_pkg::value_type b);
      smin = (a < b) ? a : b;
   endfunction

   mep_pkg::token_type tok1_ff, tok2_ff, tok3_ff, tok4_ff;

   mep_pkg::value_type           xa [mep_pkg::NUM_PROD];
   mep_pkg::value_type           xb [mep_pkg::NUM_PROD];
   logic [2*mep_pkg::HALF_W-1:0] lh_full [mep_pkg::NUM_PROD];
   logic [2*mep_pkg::HALF_W-1:0] hl_full [mep_pkg::NUM_PROD];
   logic [2*mep_pkg::HALF_W-1:0] ll_in [mep_pkg::NUM_PROD];
   logic [2*mep_pkg::HALF_W-1:0] ll_ff [mep_pkg::NUM_PROD];
   logic [mep_pkg::HALF_W-1:0]   lh_in [mep_pkg::NUM_PROD];
   logic [mep_pkg::HALF_W-1:0]   lh_ff [mep_pkg::NUM_PROD];
   logic [mep_pkg::HALF_W-1:0]   hl_in [mep_pkg::NUM_PROD];
   logic [mep_pkg::HALF_W-1:0]   hl_ff [mep_pkg::NUM_PROD];
   mep_pkg::value_type           prod_in [mep_pkg::NUM_PROD];
   mep_pkg::value_type           prod_ff [mep_pkg::NUM_PROD];

   mep_pkg::value_type as_hi_in, as_lo_in, as_hi_ff, as_lo_ff, as_hi3_ff, as_lo3_ff;
   mep_pkg::value_type cmax_in, cmin_in, cmax_ff, cmin_ff;
   mep_pkg::value_type best_in, worst_in, best_ff, worst_ff;

   // Token delay line, aligned with the registered memory data and each stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff.valid <= 1'b0;
         tok2_ff.valid <= 1'b0;
         tok3_ff.valid <= 1'b0;
         tok4_ff.valid <= 1'b0;
      end else begin
         tok1_ff <= tok_in;
         tok2_ff <= tok1_ff;
         tok3_ff <= tok2_ff;
         tok4_ff <= tok3_ff;
      end
   end

   // Stage two: the add/sub extremes and the four extreme pairings, each split into 26-bit halves.
   // Only the low 52 bits of a product matter, so the high-by-high term drops out.
   always_comb begin
      xa[0] = left_data.hi;  xb[0] = right_data.hi;
      xa[1] = left_data.hi;  xb[1] = right_data.lo;
      xa[2] = left_data.lo;  xb[2] = right_data.hi;
      xa[3] = left_data.lo;  xb[3] = right_data.lo;
      for (int q = 0; q < mep_pkg::NUM_PROD; q++) begin
         ll_in[q]   = xa[q][mep_pkg::HALF_W-1:0] * xb[q][mep_pkg::HALF_W-1:0];
         lh_full[q] = xa[q][mep_pkg::HALF_W-1:0] * xb[q][mep_pkg::VALUE_W-1:mep_pkg::HALF_W];
         hl_full[q] = xa[q][mep_pkg::VALUE_W-1:mep_pkg::HALF_W] * xb[q][mep_pkg::HALF_W-1:0];
         lh_in[q]   = lh_full[q][mep_pkg::HALF_W-1:0];
         hl_in[q]   = hl_full[q][mep_pkg::HALF_W-1:0];
      end
      if (tok1_ff.op == mep_pkg::OP_SUB) begin
         as_hi_in = left_data.hi - right_data.lo;
         as_lo_in = left_data.lo - right_data.hi;
      end else begin
         as_hi_in = left_data.hi + right_data.hi;
         as_lo_in = left_data.lo + right_data.lo;
      end
   end

   // Stage three: assemble each product modulo 2^52.
   always_comb begin
      for (int q = 0; q < mep_pkg::NUM_PROD; q++) begin
         prod_in[q] = $signed(ll_ff[q] + {lh_ff[q] + hl_ff[q], mep_pkg::HALF_W'(0)});
      end
   end

   // Stage four: candidate extremes of this split.
   always_comb begin
      if (tok3_ff.op == mep_pkg::OP_MUL) begin
         cmax_in = smax(smax(prod_ff[0], prod_ff[1]), smax(prod_ff[2], prod_ff[3]));
         cmin_in = smin(smin(prod_ff[0], prod_ff[1]), smin(prod_ff[2], prod_ff[3]));
      end else begin
         cmax_in = as_hi3_ff;
         cmin_in = as_lo3_ff;
      end
   end

   // Stage five: fold the split into the running interval extremes.
   always_comb begin
      if (tok4_ff.first) begin
         best_in  = cmax_ff;
         worst_in = cmin_ff;
      end else begin
         best_in  = smax(best_ff, cmax_ff);
         worst_in = smin(worst_ff, cmin_ff);
      end
      wb.en      = tok4_ff.valid && tok4_ff.last;
      wb.addr    = tok4_ff.addr;
      wb.data.hi = best_in;
      wb.data.lo = worst_in;
   end

   always_ff @(posedge clock) begin
      for (int q = 0; q < mep_pkg::NUM_PROD; q++) begin
         ll_ff[q]   <= ll_in[q];
         lh_ff[q]   <= lh_in[q];
         hl_ff[q]   <= hl_in[q];
         prod_ff[q] <= prod_in[q];
      end
      as_hi_ff  <= as_hi_in;
      as_lo_ff  <= as_lo_in;
      as_hi3_ff <= as_hi_ff;
      as_lo3_ff <= as_lo_ff;
      cmax_ff   <= cmax_in;
      cmin_ff   <= cmin_in;
      if (tok4_ff.valid) begin
         best_ff  <= best_in;
         worst_ff <= worst_in;
      end
   end

`ifndef ASSERT_OFF
   // Splits of one interval reach the fold stage back to back.
   a_split_stream: assert property (@(posedge clock) disable iff (reset)
      tok4_ff.valid && !tok4_ff.first |-> $past(tok4_ff.valid))
      else $error("split pipeline gap inside an interval");

   // A new interval only enters an empty pipeline.
   a_interval_start: assert property (@(posedge clock) disable iff (reset)
      tok_in.valid && tok_in.first |->
         !tok1_ff.valid && !tok2_ff.valid && !tok3_ff.valid && !tok4_ff.valid)
      else $error("interval started before the previous one was written");

   // In the cycle after a write-back the first stage of the pipeline is still empty.
   a_drain_after_write: assert property (@(posedge clock) disable iff (reset)
      wb.en |=> !tok1_ff.valid)
      else $error("split issued in the cycle of a write-back");
`endif

endmodule

// ===== rtl/core/mep_sequencer.sv =====
// Sequencer: loads digits and operators, walks intervals by length, issues one split
// per cycle except while draining, then reads the whole-range entry. Uses mep_pkg.
`timescale 1ns / 1ps

module mep_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  mep_pkg::req_type            req_data,
   output logic                        busy,
   output logic                        rsp_valid,
   output mep_pkg::rsp_type            rsp_data,
   input  mep_pkg::write_type          wb,
   input  mep_pkg::entry_type          final_data,
   output logic [mep_pkg::ADDR_W-1:0]  rd_addr_a,
   output logic [mep_pkg::ADDR_W-1:0]  rd_addr_b,
   output mep_pkg::write_type          ram_wr,
   output mep_pkg::token_type          tok
);

   typedef enum logic [4:0] {
      S_LOAD     = 5'b00001,
      S_ISSUE    = 5'b00010,
      S_DRAIN    = 5'b00100,
      S_FINAL_RD = 5'b01000,
      S_FINAL    = 5'b10000
   } state_type;

   function automatic logic [mep_pkg::ADDR_W-1:0] cell_addr(
      input logic [mep_pkg::IDX_W-1:0] row,
      input logic [mep_pkg::IDX_W-1:0] col);
      cell_addr = mep_pkg::ADDR_W'(row * mep_pkg::MAX_DIGITS + col);
   endfunction

   state_type state_ff, state_in;
   logic [mep_pkg::COUNT_W-1:0] count_ff, count_in, n_ff, n_in, n_load;
   logic                        overflow_ff, overflow_in;
   logic                        too_long_ff, too_long_in;
   logic                        done_ff, done_in;
   logic [mep_pkg::IDX_W-1:0]   len_ff, len_in, i_ff, i_in, k_ff, k_in;
   logic [mep_pkg::IDX_W-1:0]   j, k_next;
   logic                        accept, store, split_last, row_end, pass_end;
   logic [mep_pkg::DIGIT_W-1:0] digit_sat;
   mep_pkg::op_type             mode_op;
   mep_pkg::op_type             ops_ff [mep_pkg::MAX_DIGITS-1];
   logic                        rsp_valid_ff, rsp_valid_in;
   mep_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   mep_pkg::value_type          digit_value;

   // Input decode: saturate the digit and fold the unused operator code to add.
   always_comb begin
      accept = start && (state_ff == S_LOAD);
      store  = accept && (count_ff < mep_pkg::COUNT_W'(mep_pkg::MAX_DIGITS));
      n_load = store ? count_ff + mep_pkg::COUNT_W'(1) : count_ff;
      digit_sat = (req_data.digit > mep_pkg::DIGIT_W'(mep_pkg::DIGIT_MAX)) ?
                  mep_pkg::DIGIT_W'(mep_pkg::DIGIT_MAX) : req_data.digit;
      digit_value = $signed({(mep_pkg::VALUE_W - mep_pkg::DIGIT_W)'(0), digit_sat});
      case (req_data.mode)
         mep_pkg::OP_SUB: mode_op = mep_pkg::OP_SUB;
         mep_pkg::OP_MUL: mode_op = mep_pkg::OP_MUL;
         default:         mode_op = mep_pkg::OP_ADD;
      endcase
   end

   // Interval walk: interval (i, j) with j = i + len, split point k.
   always_comb begin
      j          = i_ff + len_ff;
      k_next     = k_ff + mep_pkg::IDX_W'(1);
      split_last = (k_next == j);
      row_end    = (mep_pkg::COUNT_W'(i_ff) + mep_pkg::COUNT_W'(len_ff)
                    + mep_pkg::COUNT_W'(1)) == n_ff;
      pass_end   = (mep_pkg::COUNT_W'(len_ff) + mep_pkg::COUNT_W'(1)) == n_ff;
   end

   // Split tokens and memory addresses.
   always_comb begin
      tok.valid = (state_ff == S_ISSUE);
      tok.first = (k_ff == i_ff);
      tok.last  = split_last;
      tok.op    = ops_ff[k_ff];
      tok.addr  = cell_addr(i_ff, j);
      if (state_ff == S_FINAL_RD) begin
         rd_addr_a = cell_addr(mep_pkg::IDX_W'(0),
                               mep_pkg::IDX_W'(n_ff - mep_pkg::COUNT_W'(1)));
      end else begin
         rd_addr_a = cell_addr(i_ff, k_ff);
      end
      rd_addr_b = cell_addr(k_next, j);
   end

   // Memory write: diagonal entries while loading, interval results otherwise.
   always_comb begin
      if (state_ff == S_LOAD) begin
         ram_wr.en      = store;
         ram_wr.addr    = cell_addr(count_ff[mep_pkg::IDX_W-1:0],
                                    count_ff[mep_pkg::IDX_W-1:0]);
         ram_wr.data.hi = digit_value;
         ram_wr.data.lo = digit_value;
      end else begin
         ram_wr = wb;
      end
   end

   // Control state machine.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      too_long_in  = too_long_ff;
      n_in         = n_ff;
      done_in      = done_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (store) begin
                  count_in = count_ff + mep_pkg::COUNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_data.last) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  too_long_in = overflow_ff || !store;
                  n_in        = n_load;
                  len_in      = mep_pkg::IDX_W'(1);
                  i_in        = '0;
                  k_in        = '0;
                  done_in     = 1'b0;
                  state_in    = (n_load == mep_pkg::COUNT_W'(1)) ? S_FINAL_RD : S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            if (split_last) begin
               state_in = S_DRAIN;
               if (row_end) begin
                  i_in    = '0;
                  k_in    = '0;
                  len_in  = len_ff + mep_pkg::IDX_W'(1);
                  done_in = pass_end;
               end else begin
                  i_in = i_ff + mep_pkg::IDX_W'(1);
                  k_in = i_ff + mep_pkg::IDX_W'(1);
               end
            end else begin
               k_in = k_next;
            end
         end
         S_DRAIN: begin
            if (wb.en) begin
               state_in = done_ff ? S_FINAL_RD : S_ISSUE;
            end
         end
         S_FINAL_RD: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.max_value = final_data.hi;
            rsp_data_in.min_value = final_data.lo;
            rsp_data_in.too_long  = too_long_ff;
            state_in              = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk counters, result payload and the operator store.
   always_ff @(posedge clock) begin
      too_long_ff <= too_long_in;
      n_ff        <= n_in;
      done_ff     <= done_in;
      len_ff      <= len_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      if (store && !req_data.last &&
          (count_ff < mep_pkg::COUNT_W'(mep_pkg::MAX_DIGITS - 1))) begin
         ops_ff[count_ff[mep_pkg::IDX_W-1:0]] <= mode_op;
      end
   end

   assign busy      = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A result strobe lasts exactly one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The core only becomes free again together with its result.
   a_busy_release: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // The digit count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mep_pkg::COUNT_W'(mep_pkg::MAX_DIGITS))
      else $error("digit count beyond capacity");
`endif

endmodule

// ===== rtl/core/max_expression_parenthesization_core.sv =====
// Load: one digit transaction per cycle, busy stays low until the last digit.
// On the last digit busy rises; the result strobe follows once every interval of the
// n stored digits is filled: one split per cycle through the interval memory, and
// a drain of the split pipeline after each interval until its write-back.
// Synchronous active-high reset clears the control state; the memories are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module max_expression_parenthesization_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mep_pkg::req_type  req_data,
   output logic              rsp_valid,
   output mep_pkg::rsp_type  rsp_data
);

   mep_pkg::write_type         ram_wr;
   mep_pkg::write_type         wb;
   mep_pkg::token_type         tok;
   mep_pkg::entry_type         rd_data_a;
   mep_pkg::entry_type         rd_data_b;
   logic [mep_pkg::ADDR_W-1:0] rd_addr_a;
   logic [mep_pkg::ADDR_W-1:0] rd_addr_b;

   // Load and interval control.
   mep_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .wb         (wb),
      .final_data (rd_data_a),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .ram_wr     (ram_wr),
      .tok        (tok)
   );

   // Max/min table of every sub-range.
   mep_interval_ram u_ram (
      .clock     (clock),
      .wr        (ram_wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Split evaluation pipeline.
   mep_split_unit u_split (
      .clock      (clock),
      .reset      (reset),
      .tok_in     (tok),
      .left_data  (rd_data_a),
      .right_data (rd_data_b),
      .wb         (wb)
   );

endmodule

// ===== test/mep_extremes_checker.sv =====
// Checker for the expression parenthesization core: watches both transaction channels,
// predicts the greatest and least value of each expression and compares the results.
// Depends on mep_pkg for the transaction structs, sizes and operator codes.
`timescale 1ns / 1ps

module mep_extremes_checker
   import mep_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      pending_results,
   output int      mismatch_count
);

   // Expression gathered so far, as the block stores it.
   logic [DIGIT_W-1:0] operand [MAX_DIGITS];
   op_type             operator_seq [MAX_DIGITS-1];
   int                 stored_count;
   logic               overflowed;

   // Extremes predicted for closed expressions, oldest first.
   rsp_type            awaited_extremes [$];
   int                 error_total;

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_total++;
   endtask

   // Interval pass over the stored expression: every sub-range keeps its greatest
   // and least value, and a multiply split looks at all four extreme products.
   function automatic rsp_type solve_extremes();
      longint  hi_tab [MAX_DIGITS][MAX_DIGITS];
      longint  lo_tab [MAX_DIGITS][MAX_DIGITS];
      longint  prod [NUM_PROD];
      longint  part_hi, part_lo, best, worst;
      int      j;
      rsp_type result;
      for (int p = 0; p < stored_count; p++) begin
         hi_tab[p][p] = operand[p];
         lo_tab[p][p] = operand[p];
      end
      for (int span = 1; span < stored_count; span++) begin
         for (int i = 0; i + span < stored_count; i++) begin
            j = i + span;
            best  = 0;
            worst = 0;
            for (int k = i; k < j; k++) begin
               case (operator_seq[k])
                  OP_SUB: begin
                     part_hi = hi_tab[i][k] - lo_tab[k+1][j];
                     part_lo = lo_tab[i][k] - hi_tab[k+1][j];
                  end
                  OP_MUL: begin
                     prod[0] = hi_tab[i][k] * hi_tab[k+1][j];
                     prod[1] = hi_tab[i][k] * lo_tab[k+1][j];
                     prod[2] = lo_tab[i][k] * hi_tab[k+1][j];
                     prod[3] = lo_tab[i][k] * lo_tab[k+1][j];
                     part_hi = prod[0];
                     part_lo = prod[0];
                     for (int q = 1; q < NUM_PROD; q++) begin
                        if (prod[q] > part_hi) part_hi = prod[q];
                        if (prod[q] < part_lo) part_lo = prod[q];
                     end
                  end
                  default: begin
                     part_hi = hi_tab[i][k] + hi_tab[k+1][j];
                     part_lo = lo_tab[i][k] + lo_tab[k+1][j];
                  end
               endcase
               if (k == i) begin
                  best  = part_hi;
                  worst = part_lo;
               end else begin
                  if (part_hi > best)  best  = part_hi;
                  if (part_lo < worst) worst = part_lo;
               end
            end
            hi_tab[i][j] = best;
            lo_tab[i][j] = worst;
         end
      end
      best  = hi_tab[0][stored_count-1];
      worst = lo_tab[0][stored_count-1];
      result.max_value = best[VALUE_W-1:0];
      result.min_value = worst[VALUE_W-1:0];
      result.too_long  = overflowed;
      return result;
   endfunction

   // Store one digit transaction; the closing one yields a prediction.
   task automatic absorb_token(input req_type item);
      logic [DIGIT_W-1:0] value;
      op_type             op;
      value = (item.digit > DIGIT_MAX) ? DIGIT_W'(DIGIT_MAX) : item.digit;
      case (item.mode)
         OP_SUB:  op = OP_SUB;
         OP_MUL:  op = OP_MUL;
         default: op = OP_ADD;
      endcase
      if (stored_count < MAX_DIGITS) begin
         operand[stored_count] = value;
         if (!item.last && stored_count < MAX_DIGITS - 1) begin
            operator_seq[stored_count] = op;
         end
         stored_count++;
      end else begin
         overflowed = 1'b1;
      end
      if (item.last) begin
         awaited_extremes.push_back(solve_extremes());
         stored_count = 0;
         overflowed   = 1'b0;
      end
   endtask

   // Compare one result transaction field by field with the oldest prediction.
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (awaited_extremes.size() == 0) begin
         report_mismatch("result strobe with no expression pending");
      end else begin
         want = awaited_extremes.pop_front();
         if (got.max_value !== want.max_value) begin
            report_mismatch($sformatf("max_value got %0d, expected %0d",
                                      got.max_value, want.max_value));
         end
         if (got.min_value !== want.min_value) begin
            report_mismatch($sformatf("min_value got %0d, expected %0d",
                                      got.min_value, want.min_value));
         end
         if (got.too_long !== want.too_long) begin
            report_mismatch($sformatf("too_long got %b, expected %b",
                                      got.too_long, want.too_long));
         end
      end
   endtask

   // Sample both channels at each rising edge; outputs update after the edge.
   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         overflowed   = 1'b0;
         awaited_extremes.delete();
      end else begin
         if (start && !busy) absorb_token(req_data);
         if (rsp_valid) check_result(rsp_data);
      end
      pending_results <= awaited_extremes.size();
      mismatch_count  <= error_total;
   end

endmodule

// ===== test/max_expression_parenthesization_core_tb.sv =====
// Testbench top for the expression parenthesization core: drives digit transactions,
// runs the watchdog and prints the verdict.
// Depends on mep_pkg, the core and mep_extremes_checker.
`timescale 1ns / 1ps

module max_expression_parenthesization_core_tb;
   import mep_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int ITEM_BUDGET     = 2000;
   localparam int CALM_TAIL_ITEMS = 200;
   localparam int WATCHDOG_LIMIT  = 10000;
   localparam int DRAIN_CYCLES    = 64;

   localparam logic [MODE_W-1:0]  MODE_SPARE = 2'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_TOP  = '1;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(DIGIT_MAX);

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      pending_results;
   int      mismatch_count;

   int      items_sent  = 0;
   int      idle_chance = 0;
   bit      calm        = 1'b0;
   int      idle_cycles = 0;

   max_expression_parenthesization_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   mep_extremes_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // Watchdog: end the run when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT - 1) begin
         $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one digit transaction, wait for it to be taken, then maybe pause with noise.
   task automatic send_digit(input logic [DIGIT_W-1:0] digit,
                             input logic [MODE_W-1:0]  mode,
                             input logic               last);
      req_type item;
      item.digit = digit;
      item.mode  = mode;
      item.last  = last;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      items_sent++;
      if (!calm && $urandom_range(99) < idle_chance) begin
         start    <= 1'b0;
         req_data <= req_type'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // A whole expression with random digits (some above nine) and random operators.
   task automatic send_expression(input int len);
      logic [DIGIT_W-1:0] digit;
      for (int p = 0; p < len; p++) begin
         digit = ($urandom_range(4) == 0) ? DIGIT_W'($urandom_range(10, 15))
                                          : DIGIT_W'($urandom_range(0, 9));
         send_digit(digit, MODE_W'($urandom_range(0, 3)), p == len - 1);
      end
   endtask

   initial begin
      int len;
      int roll;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone zero, lone digit above nine, spare mode as add, mixed operators.
      send_digit('0, OP_ADD, 1'b1);
      send_digit(DIGIT_TOP, MODE_SPARE, 1'b1);
      send_digit(DIGIT_W'(3), MODE_SPARE, 1'b0);
      send_digit(DIGIT_W'(4), OP_MUL, 1'b1);
      send_digit(DIGIT_W'(5), OP_SUB, 1'b0);
      send_digit(DIGIT_W'(8), OP_MUL, 1'b0);
      send_digit(DIGIT_W'(2), OP_ADD, 1'b1);

      // Full table of nines multiplied, then a closing digit that overflows.
      repeat (MAX_DIGITS) send_digit(DIGIT_NINE, OP_MUL, 1'b0);
      send_digit(DIGIT_TOP, OP_SUB, 1'b1);

      // Random expressions: mostly short, a few long up to full length, a few overflowing.
      while (items_sent < ITEM_BUDGET) begin
         calm = (items_sent >= ITEM_BUDGET - CALM_TAIL_ITEMS);
         case ($urandom_range(2))
            0:       idle_chance = 0;
            1:       idle_chance = 25;
            default: idle_chance = 60;
         endcase
         roll = $urandom_range(99);
         if (roll < 70)      len = $urandom_range(1, 5);
         else if (roll < 92) len = $urandom_range(6, 12);
         else if (roll < 97) len = $urandom_range(13, MAX_DIGITS);
         else                len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 4);
         send_expression(len);
      end
      start <= 1'b0;

      // Let every outstanding result arrive, then a short quiet stretch.
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mep_pkg.sv
rtl/core/mep_interval_ram.sv
rtl/core/mep_split_unit.sv
rtl/core/mep_sequencer.sv
rtl/core/max_expression_parenthesization_core.sv
test/mep_extremes_checker.sv
test/max_expression_parenthesization_core_tb.sv
